[design/fdm_pkg.sv]
`default_nettype none
package fdm_pkg;

  localparam int TIME_W    = 48;
  localparam int DELAY_W   = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CYL_W     = 7;
  localparam int TRAIL_W   = 32;

  typedef enum logic [1:0] {
    OP_PORT_WRITE = 2'd0,
    OP_INSERT     = 2'd1,
    OP_EJECT      = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_CONNECTED = 4'd0,
    CFG_DRIVE_KIND      = 4'd1,
    CFG_DRIVE_INDEX     = 4'd2,
    CFG_SPIN_UP         = 4'd3,
    CFG_SPIN_DOWN       = 4'd4,
    CFG_STEP_PULSE      = 4'd5,
    CFG_REVERSE_STEP    = 4'd6,
    CFG_SETTLE          = 4'd7
  } cfg_idx_t;

  localparam logic [1:0] KIND_DD  = 2'd0;
  localparam logic [1:0] KIND_HD  = 2'd1;
  localparam logic [1:0] KIND_525 = 2'd2;

  localparam int PORT_MTR  = 7;
  localparam int PORT_SEL0 = 3;
  localparam int PORT_SIDE = 2;
  localparam int PORT_DIR  = 1;
  localparam int PORT_STEP = 0;

  localparam logic [7:0] PORT_RESET  = 8'hFF;
  localparam logic [7:0] STATUS_IDLE = 8'hFF;
  localparam int STAT_READY   = 5;
  localparam int STAT_TRACK0  = 4;
  localparam int STAT_PROTECT = 3;
  localparam int STAT_CHANGE  = 2;

  localparam logic [TRAIL_W-1:0] POLL_SIG [4] = '{
    32'h01000100, 32'h00010001, 32'h02030203, 32'h03020302
  };

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] now;
    logic [7:0]        port_value;
    logic              disk_high_density;
    logic              disk_write_protect;
  } fdm_item_t;

  typedef struct packed {
    logic [7:0]       status_flags;
    logic [CYL_W-1:0] head_cylinder;
    logic             head_side;
    logic             motor_running;
    logic             motor_full;
    logic             head_settling;
    logic             head_moved;
    logic             polling_seen;
    logic             ident_bit;
  } fdm_result_t;

endpackage
`default_nettype wire

[design/fdm_if.sv]
`default_nettype none
interface fdm_cfg_if;
  import fdm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DELAY_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface fdm_item_if;
  import fdm_pkg::*;
  logic      valid;
  logic      ready;
  fdm_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface fdm_result_if;
  import fdm_pkg::*;
  logic        valid;
  logic        ready;
  fdm_result_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[design/floppy_drive_mechanics_unit.sv]
// floppy drive control-line mechanics
// channels: cfg writes one setup register per transaction (always ready);
//   item carries op, timestamp, port byte and disk flags; result returns
//   the status byte plus head and motor flags, one per item
// an accepted item sits in the input register, then its state
//   update and result are computed in a single pass and registered
// an item moves from the input register into the result register as
//   its result, which is held there until the result transaction
// throughput: one item per cycle unless the receiver stalls, set by the
//   combinational state update (one 48-bit subtract and compare per timer)
// when the receiver stalls the result register holds and the input
//   register takes one more item before item.ready drops
// reset (rst, synchronous) empties both registers, loads the port byte
//   with all lines high, clears motor, head, disk and trail state and
//   restores the setup registers to their defaults
// config writes are expected only while no item is in flight
`default_nettype none
module floppy_drive_mechanics_unit #(
  parameter int MAX_CYLINDER = 83
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fdm_cfg_if.sink     cfg,
  fdm_item_if.sink    item,
  fdm_result_if.source result
);
  import fdm_pkg::*;

  localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(MAX_CYLINDER);

  // setup registers
  logic               drive_connected;
  logic [1:0]         drive_kind;
  logic [1:0]         drive_index;
  logic [DELAY_W-1:0] spin_up_delay, spin_down_delay, step_pulse_delay;
  logic [DELAY_W-1:0] reverse_step_delay, settle_delay;

  // pipeline registers
  logic        item_valid;
  fdm_item_t   item_reg;
  logic        result_valid;
  fdm_result_t result_data;
  logic        advance;

  // drive state
  logic [7:0]         last_port, last_port_next;
  logic               motor_on, motor_on_next;
  logic               full_at_switch, full_at_switch_next;
  logic [TIME_W-1:0]  switch_time, switch_time_next;
  logic [4:0]         ident_count, ident_count_next;
  logic               ident_value, ident_value_next;
  logic [CYL_W-1:0]   cylinder_now, cylinder_now_next;
  logic               side_now, side_now_next;
  logic               disk_in, disk_in_next;
  logic               disk_hd, disk_hd_next;
  logic               disk_wprot, disk_wprot_next;
  logic               change_flag, change_flag_next;
  logic [TIME_W-1:0]  last_step_time, last_step_time_next;
  logic [TIME_W-1:0]  last_up_time, last_up_time_next;
  logic [TIME_W-1:0]  last_down_time, last_down_time_next;
  logic [TIME_W-1:0]  step_done_time, step_done_time_next;
  logic [TRAIL_W-1:0] cylinder_trail, cylinder_trail_next;

  fdm_result_t result_next;

  logic [TIME_W-1:0] now_t, el_switch, el_step, el_up, el_down;
  logic [2:0]        sel_pos;
  logic [7:0]        nv;
  logic              old_sel, new_sel, old_mtr, new_mtr, old_stp, new_stp;
  logic              speed_old, speed_new, switched, moved, motor_target;
  logic              step_down, selected_now, poll_hit;
  logic [4:0]        count_inc;

  function automatic logic ident_bit_of(input logic [4:0] cnt, input logic [1:0] idx,
                                        input logic [1:0] kind, input logic din,
                                        input logic dhd);
    logic b;
    b = 1'b1;
    if (idx == 2'd0) begin
      b = 1'b0;
    end else if (kind == KIND_HD) begin
      b = (din && dhd) ? ~cnt[0] : 1'b1;
    end else if (kind == KIND_525) begin
      b = cnt[0];
    end
    return b;
  endfunction

  assign advance      = item_valid && (!result_valid || result.ready);
  assign item.ready   = !item_valid || advance;
  assign result.valid = result_valid;
  assign result.data  = result_data;
  assign cfg.ready    = 1'b1;

  always_comb begin
    now_t     = item_reg.now;
    nv        = item_reg.port_value;
    el_switch = now_t - switch_time;
    el_step   = now_t - last_step_time;
    el_up     = now_t - last_up_time;
    el_down   = now_t - last_down_time;
    sel_pos   = 3'(PORT_SEL0) + {1'b0, drive_index};
    old_sel   = last_port[sel_pos];
    new_sel   = nv[sel_pos];
    old_mtr   = last_port[PORT_MTR];
    new_mtr   = nv[PORT_MTR];
    old_stp   = last_port[PORT_STEP];
    new_stp   = nv[PORT_STEP];
    step_down = nv[PORT_DIR];
    count_inc = ident_count + 5'd1;
    motor_target = !old_mtr || !new_mtr;

    if (motor_on) begin
      speed_old = (spin_up_delay == '0) || full_at_switch ||
                  (el_switch >= TIME_W'(spin_up_delay));
    end else begin
      speed_old = (spin_down_delay != '0) && full_at_switch &&
                  (el_switch < TIME_W'(spin_down_delay));
    end

    last_port_next      = last_port;
    motor_on_next       = motor_on;
    full_at_switch_next = full_at_switch;
    switch_time_next    = switch_time;
    ident_count_next    = ident_count;
    ident_value_next    = ident_value;
    cylinder_now_next   = cylinder_now;
    side_now_next       = side_now;
    disk_in_next        = disk_in;
    disk_hd_next        = disk_hd;
    disk_wprot_next     = disk_wprot;
    change_flag_next    = change_flag;
    last_step_time_next = last_step_time;
    last_up_time_next   = last_up_time;
    last_down_time_next = last_down_time;
    step_done_time_next = step_done_time;
    cylinder_trail_next = cylinder_trail;
    switched = 1'b0;
    moved    = 1'b0;

    unique case (op_t'(item_reg.op))
      OP_PORT_WRITE: begin
        last_port_next = nv;
        if (old_sel && !new_sel) begin
          ident_value_next = ident_bit_of(count_inc, drive_index, drive_kind,
                                          disk_in, disk_hd);
          if (motor_on != motor_target) begin
            switched            = 1'b1;
            full_at_switch_next = speed_old;
            switch_time_next    = now_t;
            motor_on_next       = motor_target;
            ident_count_next    = '0;
          end else begin
            ident_count_next = count_inc;
          end
        end
        if (!old_stp && new_stp && !old_sel) begin
          if (disk_in) begin
            change_flag_next = 1'b1;
          end
          if (el_step >= TIME_W'(step_pulse_delay)) begin
            if (step_down) begin
              if (el_up >= TIME_W'(reverse_step_delay) && cylinder_now != '0) begin
                moved               = 1'b1;
                cylinder_now_next   = cylinder_now - CYL_W'(1);
                last_down_time_next = now_t;
              end
            end else begin
              if (el_down >= TIME_W'(reverse_step_delay) && cylinder_now < CYL_MAX) begin
                moved             = 1'b1;
                cylinder_now_next = cylinder_now + CYL_W'(1);
                last_up_time_next = now_t;
              end
            end
          end
        end
        if (moved) begin
          cylinder_trail_next = {cylinder_trail[TRAIL_W-9:0], 1'b0, cylinder_now_next};
          step_done_time_next = now_t + TIME_W'(settle_delay);
          last_step_time_next = now_t;
        end
        side_now_next = !nv[PORT_SIDE];
      end
      OP_INSERT: begin
        if (!item_reg.disk_high_density || drive_kind == KIND_HD) begin
          if (disk_in) begin
            change_flag_next = 1'b0;
          end
          disk_in_next    = 1'b1;
          disk_hd_next    = item_reg.disk_high_density;
          disk_wprot_next = item_reg.disk_write_protect;
        end
      end
      OP_EJECT: begin
        if (disk_in) begin
          change_flag_next = 1'b0;
          disk_in_next     = 1'b0;
          disk_hd_next     = 1'b0;
          disk_wprot_next  = 1'b0;
        end
      end
      OP_QUERY: begin
      end
    endcase

    // right after a switch the elapsed time is zero
    if (switched) begin
      speed_new = motor_on_next ? ((spin_up_delay == '0) || full_at_switch_next)
                                : ((spin_down_delay != '0) && full_at_switch_next);
    end else begin
      speed_new = speed_old;
    end

    poll_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cylinder_trail_next == POLL_SIG[i]) begin
        poll_hit = 1'b1;
      end
    end

    selected_now = !last_port_next[sel_pos];
    result_next.status_flags = STATUS_IDLE;
    if (drive_connected && selected_now) begin
      if (speed_new ? disk_in_next : ident_value_next) begin
        result_next.status_flags[STAT_READY] = 1'b0;
      end
      if (cylinder_now_next == '0) begin
        result_next.status_flags[STAT_TRACK0] = 1'b0;
      end
      if (!(disk_in_next && !disk_wprot_next)) begin
        result_next.status_flags[STAT_PROTECT] = 1'b0;
      end
      if (!change_flag_next) begin
        result_next.status_flags[STAT_CHANGE] = 1'b0;
      end
    end
    result_next.head_cylinder = cylinder_now_next;
    result_next.head_side     = side_now_next;
    result_next.motor_running = motor_on_next;
    result_next.motor_full    = speed_new;
    result_next.head_settling = now_t < step_done_time_next;
    result_next.head_moved    = moved;
    result_next.polling_seen  = !disk_in_next && poll_hit;
    result_next.ident_bit     = ident_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_connected    <= 1'b1;
      drive_kind         <= KIND_DD;
      drive_index        <= 2'd0;
      spin_up_delay      <= '0;
      spin_down_delay    <= '0;
      step_pulse_delay   <= '0;
      reverse_step_delay <= '0;
      settle_delay       <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DRIVE_CONNECTED: begin
          // the internal drive cannot be disconnected
          if (!(drive_index == 2'd0 && !cfg.data[0])) begin
            drive_connected <= cfg.data[0];
          end
        end
        CFG_DRIVE_KIND:   drive_kind         <= cfg.data[1:0];
        CFG_DRIVE_INDEX:  drive_index        <= cfg.data[1:0];
        CFG_SPIN_UP:      spin_up_delay      <= cfg.data;
        CFG_SPIN_DOWN:    spin_down_delay    <= cfg.data;
        CFG_STEP_PULSE:   step_pulse_delay   <= cfg.data;
        CFG_REVERSE_STEP: reverse_step_delay <= cfg.data;
        CFG_SETTLE:       settle_delay       <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        item_valid <= item.valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg <= '0;
    end else if (item.valid && item.ready) begin
      item_reg <= item.data;
    end
    if (advance) begin
      result_data <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_port      <= PORT_RESET;
      motor_on       <= 1'b0;
      full_at_switch <= 1'b0;
      switch_time    <= '0;
      ident_count    <= '0;
      ident_value    <= 1'b0;
      cylinder_now   <= '0;
      side_now       <= 1'b0;
      disk_in        <= 1'b0;
      disk_hd        <= 1'b0;
      disk_wprot     <= 1'b0;
      change_flag    <= 1'b0;
      last_step_time <= '0;
      last_up_time   <= '0;
      last_down_time <= '0;
      step_done_time <= '0;
      cylinder_trail <= '0;
    end else if (advance) begin
      last_port      <= last_port_next;
      motor_on       <= motor_on_next;
      full_at_switch <= full_at_switch_next;
      switch_time    <= switch_time_next;
      ident_count    <= ident_count_next;
      ident_value    <= ident_value_next;
      cylinder_now   <= cylinder_now_next;
      side_now       <= side_now_next;
      disk_in        <= disk_in_next;
      disk_hd        <= disk_hd_next;
      disk_wprot     <= disk_wprot_next;
      change_flag    <= change_flag_next;
      last_step_time <= last_step_time_next;
      last_up_time   <= last_up_time_next;
      last_down_time <= last_down_time_next;
      step_done_time <= step_done_time_next;
      cylinder_trail <= cylinder_trail_next;
    end
  end

  a_cyl_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.head_cylinder <= CYL_MAX)
    else $error("head cylinder beyond limit");

  a_move_changes_cyl: assert property (@(posedge clk) disable iff (rst)
    advance && moved |=> cylinder_now != $past(cylinder_now))
    else $error("head move left cylinder unchanged");

  a_poll_no_disk: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.polling_seen |-> !disk_in)
    else $error("polling reported with disk present");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.head_cylinder == cylinder_now &&
                     result.data.motor_running == motor_on)
    else $error("result out of step with drive state");

endmodule
`default_nettype wire

[verif/fdm_status_checker.sv]
`timescale 1ns / 1ps
module fdm_status_checker (
  input  logic   clk,
  input  logic   rst,
  fdm_cfg_if     cfg,
  fdm_item_if    item,
  fdm_result_if  result,
  output int     fail_count,
  output int     in_flight
);
  import fdm_pkg::*;

  localparam int          MAXCYL     = 83;
  localparam logic [31:0] TRAIL_SIGS [4] = '{
    32'h01000100, 32'h00010001, 32'h02030203, 32'h03020302
  };

  // setup registers
  logic              connected_r;
  logic [1:0]        kind_r;
  logic [1:0]        index_r;
  logic [DELAY_W-1:0] spinup_r, spindown_r, pulse_r, reverse_r, settle_r;

  // drive state
  logic [7:0]        port_q;
  logic              mtr_on, full_sw, id_bit, side_q;
  logic              has_disk, disk_hd_q, disk_wp_q, changed;
  logic [TIME_W-1:0] sw_time, step_t, up_t, down_t, done_t;
  logic [4:0]        id_cnt;
  logic [CYL_W-1:0]  cyl;
  logic [63:0]       trail;

  fdm_result_t awaited_status[$];

  function automatic logic at_full(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] el;
    el = t - sw_time;
    if (mtr_on) return (spinup_r == '0) || full_sw || (el >= TIME_W'(spinup_r));
    return (spindown_r != '0) && full_sw && (el < TIME_W'(spindown_r));
  endfunction

  function automatic logic [31:0] ident_pattern();
    if (index_r == 2'd0) return 32'h0000_0000;
    if (kind_r == KIND_HD) return (has_disk && disk_hd_q) ? 32'hAAAA_AAAA : 32'hFFFF_FFFF;
    if (kind_r == KIND_525) return 32'h5555_5555;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic poll_match();
    if (has_disk) return 1'b0;
    for (int i = 0; i < 4; i++)
      if (trail[31:0] == TRAIL_SIGS[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void motor_switch(input logic on, input logic [TIME_W-1:0] t);
    if (mtr_on == on) return;
    full_sw = at_full(t);
    sw_time = t;
    mtr_on  = on;
    id_cnt  = 5'd0;
  endfunction

  function automatic logic try_step(input logic down, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] el;
    if (has_disk) changed = 1'b1;
    el = t - step_t;
    if (el < TIME_W'(pulse_r)) return 1'b0;
    if (down) begin
      el = t - up_t;
      if (el < TIME_W'(reverse_r)) return 1'b0;
      if (cyl == '0) return 1'b0;
      cyl    = cyl - CYL_W'(1);
      down_t = t;
    end else begin
      el = t - down_t;
      if (el < TIME_W'(reverse_r)) return 1'b0;
      if (cyl >= CYL_W'(MAXCYL)) return 1'b0;
      cyl  = cyl + CYL_W'(1);
      up_t = t;
    end
    trail  = {trail[55:0], 1'b0, cyl};
    done_t = t + TIME_W'(settle_r);
    step_t = t;
    return 1'b1;
  endfunction

  function automatic logic apply_port(input logic [7:0] nv, input logic [TIME_W-1:0] t);
    logic [7:0]  ov, sel;
    logic [31:0] pat;
    logic        moved;
    ov     = port_q;
    sel    = 8'h08 << index_r;
    moved  = 1'b0;
    port_q = nv;
    if ((ov & sel) != 8'h00 && (nv & sel) == 8'h00) begin
      id_cnt = id_cnt + 5'd1;
      pat    = ident_pattern();
      id_bit = pat[5'd31 - id_cnt];
      motor_switch(!(ov[PORT_MTR] && nv[PORT_MTR]), t);
    end
    if (!ov[PORT_STEP] && nv[PORT_STEP] && (ov & sel) == 8'h00)
      moved = try_step(nv[PORT_DIR], t);
    side_q = !nv[PORT_SIDE];
    return moved;
  endfunction

  function automatic logic [7:0] status_byte(input logic [TIME_W-1:0] t);
    logic [7:0] sel, r;
    sel = 8'h08 << index_r;
    r   = STATUS_IDLE;
    if (connected_r && (port_q & sel) == 8'h00) begin
      if (!at_full(t)) begin
        if (id_bit) r[STAT_READY] = 1'b0;
      end else if (has_disk) begin
        r[STAT_READY] = 1'b0;
      end
      if (cyl == '0) r[STAT_TRACK0] = 1'b0;
      if (!(has_disk && !disk_wp_q)) r[STAT_PROTECT] = 1'b0;
      if (!changed) r[STAT_CHANGE] = 1'b0;
    end
    return r;
  endfunction

  function automatic fdm_result_t drive_response(input fdm_item_t it);
    fdm_result_t r;
    logic        moved;
    moved = 1'b0;
    case (op_t'(it.op))
      OP_PORT_WRITE: moved = apply_port(it.port_value, it.now);
      OP_INSERT: begin
        if (!it.disk_high_density || kind_r == KIND_HD) begin
          if (has_disk) changed = 1'b0;
          has_disk  = 1'b1;
          disk_hd_q = it.disk_high_density;
          disk_wp_q = it.disk_write_protect;
        end
      end
      OP_EJECT: begin
        if (has_disk) begin
          changed   = 1'b0;
          has_disk  = 1'b0;
          disk_hd_q = 1'b0;
          disk_wp_q = 1'b0;
        end
      end
      default: ;
    endcase
    r.status_flags  = status_byte(it.now);
    r.head_cylinder = cyl;
    r.head_side     = side_q;
    r.motor_running = mtr_on;
    r.motor_full    = at_full(it.now);
    r.head_settling = it.now < done_t;
    r.head_moved    = moved;
    r.polling_seen  = poll_match();
    r.ident_bit     = id_bit;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    fdm_result_t want, got;
    if (rst) begin
      connected_r = 1'b1;
      kind_r      = KIND_DD;
      index_r     = 2'd0;
      spinup_r    = '0;
      spindown_r  = '0;
      pulse_r     = '0;
      reverse_r   = '0;
      settle_r    = '0;
      port_q      = PORT_RESET;
      mtr_on      = 1'b0;
      full_sw     = 1'b0;
      id_bit      = 1'b0;
      side_q      = 1'b0;
      has_disk    = 1'b0;
      disk_hd_q   = 1'b0;
      disk_wp_q   = 1'b0;
      changed     = 1'b0;
      sw_time     = '0;
      step_t      = '0;
      up_t        = '0;
      down_t      = '0;
      done_t      = '0;
      id_cnt      = '0;
      cyl         = '0;
      trail       = '0;
      awaited_status.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DRIVE_CONNECTED: if (index_r != 2'd0 || cfg.data[0]) connected_r = cfg.data[0];
          CFG_DRIVE_KIND:      kind_r = cfg.data[1:0];
          CFG_DRIVE_INDEX:     index_r = cfg.data[1:0];
          CFG_SPIN_UP:         spinup_r = cfg.data;
          CFG_SPIN_DOWN:       spindown_r = cfg.data;
          CFG_STEP_PULSE:      pulse_r = cfg.data;
          CFG_REVERSE_STEP:    reverse_r = cfg.data;
          CFG_SETTLE:          settle_r = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) awaited_status.push_back(drive_response(item.data));
      if (result.valid && result.ready) begin
        got = result.data;
        if (awaited_status.size() == 0) begin
          $error("result transaction with no item pending");
          fail_count++;
        end else begin
          want = awaited_status.pop_front();
          check_field("status_flags", want.status_flags, got.status_flags);
          check_field("head_cylinder", 8'(want.head_cylinder), 8'(got.head_cylinder));
          check_field("head_side", 8'(want.head_side), 8'(got.head_side));
          check_field("motor_running", 8'(want.motor_running), 8'(got.motor_running));
          check_field("motor_full", 8'(want.motor_full), 8'(got.motor_full));
          check_field("head_settling", 8'(want.head_settling), 8'(got.head_settling));
          check_field("head_moved", 8'(want.head_moved), 8'(got.head_moved));
          check_field("polling_seen", 8'(want.polling_seen), 8'(got.polling_seen));
          check_field("ident_bit", 8'(want.ident_bit), 8'(got.ident_bit));
        end
      end
    end
    in_flight <= awaited_status.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import fdm_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 175;
  localparam int         HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fdm_cfg_if    cfg_ch ();
  fdm_item_if   item_ch ();
  fdm_result_if result_ch ();

  int fails;
  int pending;

  floppy_drive_mechanics_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  fdm_status_checker mon (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fails),
    .in_flight  (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [TIME_W-1:0] t_cur;
  logic [7:0]        port_cur;
  logic [1:0]        cur_index;
  int                max_gap;
  bit                long_hold;
  int                sent;

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '1;
    if (r < 3) return '0;
    return DELAY_W'($urandom_range(1, 60));
  endfunction

  task automatic tick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) t_cur = t_cur + TIME_W'($urandom_range(0, 15));
    else if (r < 90) t_cur = t_cur + TIME_W'($urandom_range(0, 300));
    else if (r < 98) t_cur = t_cur + TIME_W'($urandom_range(0, 1 << 25));
    else t_cur = TIME_W'({$urandom, $urandom});
  endtask

  // leaves valid high so back-to-back transactions need no extra edge
  task automatic push_item(input op_t op, input logic [7:0] pv, input logic hd,
                           input logic wp);
    fdm_item_t it;
    int        gap;
    it.op                 = op;
    it.now                = t_cur;
    it.port_value         = pv;
    it.disk_high_density  = hd;
    it.disk_write_protect = wp;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == OP_PORT_WRITE) port_cur = pv;
    sent++;
  endtask

  task automatic step_pair(input logic down);
    logic [7:0] v, sel;
    sel = 8'h08 << cur_index;
    v   = port_cur & ~sel;
    v[PORT_STEP] = 1'b0;
    v[PORT_DIR]  = down;
    if ($urandom_range(0, 5) == 0) v[PORT_SIDE] = ~v[PORT_SIDE];
    if ($urandom_range(0, 7) == 0) v[PORT_MTR] = ~v[PORT_MTR];
    tick_time();
    push_item(OP_PORT_WRITE, v, rbit(), rbit());
    v[PORT_STEP] = 1'b1;
    tick_time();
    push_item(OP_PORT_WRITE, v, rbit(), rbit());
  endtask

  task automatic select_pulse();
    logic [7:0] v, sel;
    sel = 8'h08 << cur_index;
    v   = port_cur | sel;
    v[PORT_MTR] = rbit();
    tick_time();
    push_item(OP_PORT_WRITE, v, rbit(), rbit());
    v = v & ~sel;
    v[PORT_MTR] = rbit();
    tick_time();
    push_item(OP_PORT_WRITE, v, rbit(), rbit());
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DELAY_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic setup_drive(input int p);
    logic               conn;
    logic [1:0]         kind, idx;
    logic [DELAY_W-1:0] d [5];
    conn = 1'b1;
    kind = 2'($urandom_range(0, 3));
    idx  = 2'($urandom_range(0, 3));
    for (int i = 0; i < 5; i++) d[i] = pick_delay();
    case (p)
      0: begin
        // disconnect request on the internal drive, expected to be ignored
        conn = 1'b0;
        kind = KIND_HD;
        idx  = 2'd1;
        for (int i = 0; i < 5; i++) d[i] = '0;
      end
      1: begin
        kind = KIND_525;
        idx  = 2'd3;
        for (int i = 0; i < 5; i++) d[i] = '1;
      end
      2: begin
        kind = KIND_UNKNOWN;
        idx  = 2'd2;
      end
      3: begin
        conn = 1'b0;
        kind = KIND_DD;
        idx  = 2'd0;
      end
      default: ;
    endcase
    item_ch.valid <= 1'b0;
    drain();
    write_reg(CFG_DRIVE_CONNECTED, DELAY_W'(conn));
    write_reg(CFG_DRIVE_KIND, DELAY_W'(kind));
    write_reg(CFG_DRIVE_INDEX, DELAY_W'(idx));
    write_reg(CFG_SPIN_UP, d[0]);
    write_reg(CFG_SPIN_DOWN, d[1]);
    write_reg(CFG_STEP_PULSE, d[2]);
    write_reg(CFG_REVERSE_STEP, d[3]);
    write_reg(CFG_SETTLE, d[4]);
    cfg_ch.valid <= 1'b0;
    cur_index = idx;
  endtask

  task automatic random_phase(input int n);
    int   stop, r, len, pattern;
    logic down;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(0, 15) == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 9;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // burst of steps: one direction, alternating, or random
        pattern = $urandom_range(0, 2);
        len     = $urandom_range(1, 12);
        down    = rbit();
        for (int k = 0; k < len; k++) begin
          step_pair(down);
          if (pattern == 1) down = ~down;
          else if (pattern == 2) down = rbit();
        end
      end else if (r < 67) begin
        select_pulse();
      end else if (r < 77) begin
        tick_time();
        push_item(OP_PORT_WRITE, 8'($urandom), rbit(), rbit());
      end else if (r < 85) begin
        tick_time();
        push_item(OP_INSERT, 8'($urandom), rbit(), rbit());
      end else if (r < 92) begin
        tick_time();
        push_item(OP_EJECT, 8'($urandom), rbit(), rbit());
      end else if (r < 96) begin
        tick_time();
        push_item(OP_QUERY, 8'($urandom), rbit(), rbit());
      end else begin
        tick_time();
        push_item(op_t'($urandom_range(0, 3)), 8'($urandom), rbit(), rbit());
      end
    end
  endtask

  // receiver side
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    t_cur     = '0;
    port_cur  = PORT_RESET;
    cur_index = 2'd0;
    max_gap   = 9;
    long_hold = 1'b0;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset defaults
    t_cur = 48'd0;  push_item(OP_QUERY, 8'h00, 1'b0, 1'b0);
    t_cur = 48'd1;  push_item(OP_EJECT, 8'h00, 1'b0, 1'b0);
    t_cur = 48'd2;  push_item(OP_INSERT, 8'h00, 1'b1, 1'b1);
    t_cur = 48'd3;  push_item(OP_INSERT, 8'h00, 1'b0, 1'b1);
    t_cur = 48'd4;  push_item(OP_INSERT, 8'h00, 1'b0, 1'b0);
    t_cur = 48'd5;  push_item(OP_PORT_WRITE, 8'h77, 1'b0, 1'b0);
    t_cur = 48'd6;  push_item(OP_PORT_WRITE, 8'h76, 1'b0, 1'b0);
    t_cur = 48'd7;  push_item(OP_PORT_WRITE, 8'h77, 1'b0, 1'b0);
    t_cur = 48'd8;  push_item(OP_PORT_WRITE, 8'h74, 1'b0, 1'b0);
    t_cur = 48'd9;  push_item(OP_PORT_WRITE, 8'h75, 1'b0, 1'b0);
    t_cur = 48'd10; push_item(OP_PORT_WRITE, 8'h00, 1'b1, 1'b1);
    t_cur = 48'd11; push_item(OP_PORT_WRITE, 8'hFF, 1'b0, 1'b0);
    t_cur = 48'd12; push_item(OP_QUERY, 8'hFF, 1'b0, 1'b0);
    t_cur = 48'd13; push_item(OP_PORT_WRITE, 8'hF7, 1'b0, 1'b0);
    t_cur = 48'd14; push_item(OP_EJECT, 8'h00, 1'b0, 1'b0);
    // no disk: step back and forth near track zero
    step_pair(1'b0);
    step_pair(1'b1);
    step_pair(1'b0);
    step_pair(1'b1);
    t_cur = '1;     push_item(OP_QUERY, 8'hFF, 1'b1, 1'b1);
    t_cur = '0;     push_item(OP_QUERY, 8'h00, 1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      setup_drive(p);
      if (p == 4) begin
        max_gap   = 0;
        long_hold = 1'b1;
      end
      random_phase(PHASE_ITEMS / 2);
      if (p == 6) begin
        item_ch.valid <= 1'b0;
        drain();
      end
      random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    item_ch.valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
